@@ src/rwlt_pkg.sv @@
// Shared types and constants for the reader/writer lock table.
package rwlt_pkg;

    localparam int unsigned ACTION_W = 2;
    localparam int unsigned LOCK_ID_W = 8;
    localparam int unsigned CLIENT_W = 4;

    // Table geometry, fixed by the lock id and client field widths
    localparam int unsigned NUM_LOCKS = 256;
    localparam int unsigned MAX_CLIENTS = 16;

    localparam logic [1:0] ACT_LOCK_RD = 2'd0;
    localparam logic [1:0] ACT_LOCK_WR = 2'd1;
    localparam logic [1:0] ACT_REL_RD = 2'd2;
    localparam logic [1:0] ACT_REL_WR = 2'd3;

    localparam logic [1:0] MODE_UNLOCKED = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_RW = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [LOCK_ID_W-1:0] lock_id;
        logic [CLIENT_W-1:0] requester;
    } req_t;

    typedef struct packed {
        logic granted;
        logic new_holder_valid;
        logic [CLIENT_W-1:0] new_holder;
        logic last;
    } rsp_t;

    // Command handed from the front end to the back end
    typedef struct packed {
        logic is_lock;
        logic is_write;
        logic [LOCK_ID_W-1:0] lock_id;
        logic [CLIENT_W-1:0] requester;
    } cmd_t;

endpackage

@@ src/rwlt_front.sv @@
// Front end: accept requests, classify them and queue commands for the back end.
module rwlt_front
(
    input  logic clk,
    input  logic rst_n,
    input  rwlt_pkg::req_t req,
    input  logic req_push,
    output logic req_full,
    output rwlt_pkg::cmd_t cmd,
    output logic cmd_valid,
    input  logic cmd_take
);
    import rwlt_pkg::*;

    cmd_t q_reg [2];
    logic wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;
    cmd_t new_cmd;

    // Classify the incoming request
    always_comb
    begin
        new_cmd.is_lock = (req.action == ACT_LOCK_RD) || (req.action == ACT_LOCK_WR);
        new_cmd.is_write = (req.action == ACT_LOCK_WR) || (req.action == ACT_REL_WR);
        new_cmd.lock_id = req.lock_id;
        new_cmd.requester = req.requester;
    end

    assign req_full = cnt_reg[1];
    assign cmd_valid = cnt_reg != 2'd0;
    assign cmd = q_reg[rd_ptr_reg];
    assign do_push = req_push && !req_full;
    assign do_pop = cmd_take && cmd_valid;

    // Advance the two-entry queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    // Hold queued payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

@@ src/rwlt_back.sv @@
// Back end: read-modify-write of a lock entry, with release drain.
module rwlt_back
(
    input  logic clk,
    input  logic rst_n,
    input  logic retry_mode,
    input  rwlt_pkg::cmd_t cmd,
    input  logic cmd_valid,
    output logic cmd_take,
    output rwlt_pkg::rsp_t rsp,
    output logic rsp_empty,
    input  logic rsp_pop
);
    import rwlt_pkg::*;

    localparam int unsigned LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int unsigned CW = $clog2(MAX_CLIENTS);
    localparam int unsigned NW = $clog2(MAX_CLIENTS + 1);
    localparam int unsigned EW = 2 + 3 * MAX_CLIENTS + CW + NW;
    localparam int unsigned CAP = 16;
    localparam int unsigned RCW = 5;

    typedef struct packed {
        logic [1:0] mode;
        logic [MAX_CLIENTS-1:0] hold;
        logic [MAX_CLIENTS-1:0] wrd;
        logic [MAX_CLIENTS-1:0] wwr;
        logic [CW-1:0] head;
        logic [NW-1:0] count;
    } ent_t;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_EXEC = 3'd2;
    localparam logic [2:0] ST_FRD = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_ENQ = 3'd5;
    localparam logic [2:0] ST_OUT = 3'd6;
    localparam logic [2:0] ST_EPOCH = 3'd7;

    // Entry memory with an epoch-free clearing pass after reset
    logic [EW-1:0] ent_mem [NUM_LOCKS];
    logic [CW-1:0] fifo_mem [NUM_LOCKS*MAX_CLIENTS];

    logic [2:0] st_reg, st_next;
    logic [LW:0] clr_reg;
    cmd_t c_reg;
    ent_t e_reg, e_next;
    logic [EW-1:0] ent_rd;
    logic [CW-1:0] front_rd;
    logic [LW+CW-1:0] f_raddr, f_waddr;
    logic f_we;
    logic [CW-1:0] f_wdata;
    logic e_we;
    logic [RCW-1:0] n_reg;
    logic [CW-1:0] w_reg;
    logic [CW-1:0] last_w_reg;
    logic ok_reg;

    // Result queue
    rsp_t rq_reg [2];
    logic rq_wp_reg, rq_rp_reg;
    logic [1:0] rq_cnt_reg;
    logic rq_push;
    rsp_t rq_din;

    logic [LW-1:0] lid;
    logic [MAX_CLIENTS-1:0] rbit, wbit;

    assign rsp_empty = rq_cnt_reg == 2'd0;
    assign rsp = rq_reg[rq_rp_reg];
    assign lid = c_reg.lock_id[LW-1:0];
    assign rbit = MAX_CLIENTS'(1) << c_reg.requester[CW-1:0];
    assign wbit = MAX_CLIENTS'(1) << w_reg;
    assign cmd_take = (st_reg == ST_IDLE) && clr_reg[LW] && cmd_valid;

    // Lock rule evaluation on an entry copy; returns granted and updates entry
    function automatic logic do_lock(inout ent_t e, input logic wr,
                                     input logic [CW-1:0] r, input logic [CW-1:0] fr,
                                     output logic enq);
        logic [MAX_CLIENTS-1:0] b, fb;
        logic g;
        b = MAX_CLIENTS'(1) << r;
        fb = MAX_CLIENTS'(1) << fr;
        g = 1'b0;
        enq = 1'b0;
        if (e.mode == MODE_UNLOCKED)
        begin
            if (e.count == '0)
                g = 1'b1;
            else if (fr == r)
            begin
                e.wrd = e.wrd & ~fb;
                e.wwr = e.wwr & ~fb;
                e.head = e.head + CW'(1);
                e.count = e.count - NW'(1);
                g = 1'b1;
            end
            if (g)
            begin
                e.mode = wr ? MODE_WRITE : MODE_READ;
                e.hold = b;
            end
        end
        else if (e.mode == MODE_READ)
        begin
            if (!wr)
            begin
                if ((e.hold & b) != '0)
                    g = 1'b1;
                else if (e.count != '0 && (e.wwr & fb) != '0)
                    g = 1'b0;
                else
                begin
                    e.hold = e.hold | b;
                    g = 1'b1;
                end
            end
            else if (e.hold == b)
            begin
                e.mode = MODE_RW;
                g = 1'b1;
            end
        end
        else
        begin
            if ((e.hold & b) != '0)
            begin
                if (!wr)
                    e.mode = MODE_RW;
                g = 1'b1;
            end
        end
        if (!g)
        begin
            if (((e.wrd | e.wwr) & b) == '0)
            begin
                if (e.count < NW'(MAX_CLIENTS))
                begin
                    enq = 1'b1;
                    e.count = e.count + NW'(1);
                    if (wr) e.wwr = e.wwr | b; else e.wrd = e.wrd | b;
                end
            end
            else if (wr) e.wwr = e.wwr | b;
            else e.wrd = e.wrd | b;
        end
        return g;
    endfunction

    // Next entry, write strobes and results for the current step
    logic g_c, enq_c, ok_c, g2, enq2, ign;
    ent_t t;
    always_comb
    begin
        st_next = st_reg;
        e_next = e_reg;
        e_we = 1'b0;
        f_we = 1'b0;
        f_waddr = {lid, e_reg.head + e_reg.count[CW-1:0]};
        f_wdata = c_reg.requester[CW-1:0];
        f_raddr = {lid, e_reg.head};
        rq_push = 1'b0;
        rq_din = '0;
        g_c = 1'b0;
        enq_c = 1'b0;
        ok_c = 1'b1;
        g2 = 1'b0;
        enq2 = 1'b0;
        ign = 1'b0;
        t = e_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (cmd_take) st_next = ST_READ;
            end
            ST_READ:
            begin
                e_next = ent_t'(ent_rd);
                st_next = ST_EPOCH;
            end
            ST_EPOCH:
            begin
                st_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (c_reg.is_lock)
                begin
                    g_c = do_lock(t, c_reg.is_write, c_reg.requester[CW-1:0], front_rd,
                                  enq_c);
                    e_next = t;
                    e_we = 1'b1;
                    f_we = enq_c;
                    rq_din.granted = g_c;
                    st_next = ST_OUT;
                end
                else
                begin
                    st_next = ST_OUT;
                    if ((e_reg.hold & rbit) != '0)
                    begin
                        ign = 1'b1;
                        if (!c_reg.is_write)
                        begin
                            if (e_reg.mode == MODE_READ)
                            begin
                                t.hold = e_reg.hold & ~rbit;
                                if (t.hold == '0)
                                begin
                                    t.mode = MODE_UNLOCKED;
                                    ign = 1'b0;
                                end
                            end
                            else if (e_reg.mode == MODE_RW)
                                t.mode = MODE_WRITE;
                        end
                        else if (e_reg.mode == MODE_WRITE)
                        begin
                            t.hold = e_reg.hold & ~rbit;
                            t.mode = MODE_UNLOCKED;
                            ign = 1'b0;
                        end
                        else if (e_reg.mode == MODE_RW)
                        begin
                            t.mode = MODE_READ;
                            ign = 1'b0;
                        end
                        e_next = t;
                        e_we = 1'b1;
                        if (!ign && !retry_mode) st_next = ST_FRD;
                    end
                end
            end
            ST_FRD:
            begin
                // wait for the head slot read and for room to pass on a held result
                if (e_reg.count == '0 || n_reg == RCW'(CAP))
                    st_next = ST_OUT;
                else if (rq_cnt_reg != 2'd2)
                    st_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if ((e_reg.wwr & wbit) != '0)
                begin
                    g2 = do_lock(t, 1'b1, w_reg, w_reg, enq2);
                    ok_c = g2;
                end
                if ((e_reg.wrd & wbit) != '0)
                begin
                    g2 = do_lock(t, 1'b0, w_reg, front_rd, enq2);
                    ok_c = ok_c && g2;
                end
                if (!ok_c)
                    st_next = ST_OUT;
                else
                begin
                    if (t.count != '0 && front_rd == w_reg && t.head == e_reg.head)
                    begin
                        t.wrd = t.wrd & ~wbit;
                        t.wwr = t.wwr & ~wbit;
                        t.head = t.head + CW'(1);
                        t.count = t.count - NW'(1);
                    end
                    // pass on the previous grant; the newest one waits for its last flag
                    if (n_reg != '0)
                    begin
                        rq_din.new_holder_valid = 1'b1;
                        rq_din.new_holder = CLIENT_W'(last_w_reg);
                        rq_push = 1'b1;
                    end
                    st_next = ST_ENQ;
                end
                e_next = t;
                e_we = 1'b1;
                f_raddr = {lid, t.head};
            end
            ST_ENQ:
            begin
                st_next = ST_FRD;
            end
            ST_OUT:
            begin
                if (rq_cnt_reg != 2'd2)
                begin
                    if (n_reg != '0)
                    begin
                        rq_din.new_holder_valid = 1'b1;
                        rq_din.new_holder = CLIENT_W'(last_w_reg);
                    end
                    else
                        rq_din.granted = ok_reg;
                    rq_din.last = 1'b1;
                    rq_push = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // Memories: entry table and wait slots, registered reads
    always_ff @(posedge clk)
    begin
        if (!clr_reg[LW])
            ent_mem[clr_reg[LW-1:0]] <= '0;
        else if (e_we)
            ent_mem[lid] <= e_next;
        ent_rd <= ent_mem[cmd.lock_id[LW-1:0]];
        if (f_we)
            fifo_mem[f_waddr] <= f_wdata;
        front_rd <= fifo_mem[f_raddr];
    end

    // Control state and drain bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            clr_reg <= '0;
            n_reg <= '0;
            last_w_reg <= '0;
            ok_reg <= 1'b0;
            rq_wp_reg <= 1'b0;
            rq_rp_reg <= 1'b0;
            rq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (!clr_reg[LW]) clr_reg <= clr_reg + 1'b1;
            st_reg <= st_next;
            if (st_reg == ST_IDLE)
            begin
                n_reg <= '0;
                ok_reg <= 1'b0;
            end
            if (st_reg == ST_EXEC) ok_reg <= rq_din.granted;
            if (st_reg == ST_DRAIN && st_next == ST_ENQ)
            begin
                n_reg <= n_reg + 1'b1;
                last_w_reg <= w_reg;
            end
            rq_wp_reg <= rq_wp_reg ^ rq_push;
            rq_rp_reg <= rq_rp_reg ^ (rsp_pop && !rsp_empty);
            rq_cnt_reg <= rq_cnt_reg + {1'b0, rq_push} - {1'b0, rsp_pop && !rsp_empty};
        end
    end

    // Hold command, entry copy and drain candidate
    always_ff @(posedge clk)
    begin
        if (cmd_take) c_reg <= cmd;
        e_reg <= e_next;
        if (st_reg == ST_FRD) w_reg <= front_rd;
        if (rq_push) rq_reg[rq_wp_reg] <= rq_din;
    end

endmodule

@@ src/reader_writer_lock_table.sv @@
// Top level of the reader/writer lock table.
// Channel | Direction | Handshake       | Payload
// req     | in        | push / full     | rwlt_pkg::req_t
// rsp     | out       | pop / empty     | rwlt_pkg::rsp_t
// cfg     | in        | cfg_we          | retry_mode bit
// Back end steps per request: take, entry read, slot read, update and result.
// With retry_mode clear, a release that frees or downgrades the lock adds a
// drain of slot read, grant and enqueue per granted waiter. After reset all
// entries are cleared before requests are taken. A full result queue stalls
// the back end; a two-entry command queue lets the front accept meanwhile.
module reader_writer_lock_table
(
    input  logic clk,
    input  logic rst_n,
    input  rwlt_pkg::req_t req,
    input  logic push,
    output logic full,
    output rwlt_pkg::rsp_t rsp,
    output logic empty,
    input  logic pop,
    input  logic cfg_we,
    input  logic cfg_data
);
    import rwlt_pkg::*;

    cmd_t cmd;
    logic cmd_valid, cmd_take;
    logic retry_mode_reg;

    // Hold the retry register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) retry_mode_reg <= 1'b0;
        else if (cfg_we) retry_mode_reg <= cfg_data;
    end

    rwlt_front u_front (
        .clk(clk), .rst_n(rst_n), .req(req), .req_push(push), .req_full(full),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
    );

    rwlt_back u_back (
        .clk(clk), .rst_n(rst_n), .retry_mode(retry_mode_reg), .cmd(cmd),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take), .rsp(rsp), .rsp_empty(empty),
        .rsp_pop(pop)
    );

`ifndef NO_ASSERTIONS
    a_last_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && rsp.granted |-> !rsp.new_holder_valid && rsp.last)
        else $error("grant with waiter result");
    a_waiter_not_granted: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && rsp.new_holder_valid |-> !rsp.granted)
        else $error("waiter result marked granted");
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !rsp.new_holder_valid |-> rsp.new_holder == '0)
        else $error("stray holder");
`endif

endmodule
